// ===== rtl/fpfa_pkg.sv =====
// Package with shared constants, codes and item types of the fixed partition fit allocator.
package fpfa_pkg;

   localparam int MAX_PARTS  = 16;
   localparam int MAX_PROCS  = 16;
   localparam int SIZE_BITS  = 10;

   localparam int PART_IDX_W = $clog2(MAX_PARTS);
   localparam int PROC_IDX_W = $clog2(MAX_PROCS);
   localparam int PROC_CNT_W = $clog2(MAX_PROCS + 1);
   localparam int SCAN_LEN   = (MAX_PARTS > MAX_PROCS) ? MAX_PARTS : MAX_PROCS;
   localparam int SCAN_W     = $clog2(SCAN_LEN);

   localparam int OP_W       = 2;
   localparam int POLICY_W   = 2;
   localparam int PARTS_W    = 5;
   localparam int SUM_W      = 14;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTS_IN_USE = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]       opcode;
      logic [3:0]            part_index;
      logic [SIZE_BITS-1:0]  part_size;
      logic                  part_busy;
      logic [SIZE_BITS-1:0]  process_size;
   } req_type;

   typedef struct packed {
      logic [OP_W-1:0]       kind;
      logic                  placed;
      logic [3:0]            placed_index;
      logic [SIZE_BITS-1:0]  leftover;
      logic [SUM_W-1:0]      internal_total;
      logic [SIZE_BITS-1:0]  external_frag;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

// ===== rtl/fpfa_ctrl.sv =====
// Controller state machine that sequences accept, scan and commit of each item.
module fpfa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [fpfa_pkg::OP_W-1:0]  req_opcode,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fpfa_pkg::cmd_type          cmd,
   input  fpfa_pkg::status_type       status
);
   import fpfa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               if (req_opcode == OP_LOAD) begin
                  state_in = S_COMMIT;
               end else if (req_opcode == OP_ALLOC || req_opcode == OP_FINISH) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_COMMIT))
      else $error("result raised outside commit");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("commit into an occupied output register");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && status.scan_last) |=> state_ff == S_COMMIT)
      else $error("scan end did not lead to commit");

   a_load_direct: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_LOAD) |=> state_ff == S_COMMIT)
      else $error("load item did not go straight to commit");
`endif

endmodule

// ===== rtl/fpfa_dp.sv =====
// Datapath with partition and unplaced stores, scan registers, totals and result register.
module fpfa_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  fpfa_pkg::req_type               req_data,
   output fpfa_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  fpfa_pkg::cmd_type               cmd,
   output fpfa_pkg::status_type            status
);
   import fpfa_pkg::*;

   logic [SIZE_BITS-1:0]  part_size_mem [MAX_PARTS];
   logic                  part_filled_ff [MAX_PARTS];
   logic [SIZE_BITS-1:0]  unplaced_mem [MAX_PROCS];

   logic [POLICY_W-1:0]   policy_ff;
   logic [PARTS_W-1:0]    parts_ff;
   req_type               req_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [SCAN_W-1:0]     cnt_ff;
   logic [SCAN_W-1:0]     cnt_in;
   logic [SIZE_BITS-1:0]  size_rd_ff;
   logic [SIZE_BITS-1:0]  unplaced_rd_ff;
   logic                  found_ff;
   logic                  found_in;
   logic [PART_IDX_W-1:0] pick_ff;
   logic [PART_IDX_W-1:0] pick_in;
   logic [SIZE_BITS-1:0]  best_ff;
   logic [SIZE_BITS-1:0]  best_in;
   logic [SIZE_BITS-1:0]  ext_ff;
   logic [SIZE_BITS-1:0]  ext_in;
   logic [SUM_W-1:0]      sum_ff;
   logic [SUM_W-1:0]      sum_in;
   logic [PROC_CNT_W-1:0] count_ff;
   logic [PROC_CNT_W-1:0] count_in;

   logic [PART_IDX_W-1:0] part_addr;
   logic [SIZE_BITS-1:0]  cur_size;
   logic                  cur_filled;
   logic [SIZE_BITS-1:0]  cur_unplaced;
   logic                  part_active;
   logic                  proc_active;
   logic                  fits;
   logic                  take;
   logic                  fit_ok;
   logic [SIZE_BITS-1:0]  left;
   logic [SUM_W:0]        sum_wide;
   logic [SUM_W-1:0]      sum_sat;

   assign part_addr    = cnt_ff[PART_IDX_W-1:0];
   assign cur_size     = size_rd_ff;
   assign cur_filled   = part_filled_ff[part_addr];
   assign cur_unplaced = unplaced_rd_ff;
   assign part_active  = (parts_ff >= PARTS_W'(MAX_PARTS)) || (PARTS_W'(cnt_ff) < parts_ff);
   assign proc_active  = PROC_CNT_W'(cnt_ff) < count_ff;
   assign fits         = cur_size >= req_ff.process_size;
   assign status.scan_last = (cnt_ff == SCAN_W'(SCAN_LEN - 1));

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.latch) begin
         cnt_in = '0;
      end else if (cmd.step) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      take = 1'b0;
      case (policy_ff)
         POLICY_BEST:  take = fits && (!found_ff || cur_size < best_ff);
         POLICY_WORST: take = !found_ff || cur_size > best_ff;
         default:      take = fits && !found_ff;
      endcase
      take = take && part_active && !cur_filled;
   end

   assign fit_ok   = found_ff && (best_ff >= req_ff.process_size);
   assign left     = best_ff - req_ff.process_size;
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(left);
   assign sum_sat  = (sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];

   always_comb begin
      found_in = found_ff;
      pick_in  = pick_ff;
      best_in  = best_ff;
      ext_in   = ext_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      rsp_in   = rsp_ff;
      if (cmd.latch) begin
         found_in = 1'b0;
         pick_in  = '0;
         best_in  = '0;
         ext_in   = '0;
      end
      if (cmd.step) begin
         if (req_ff.opcode == OP_ALLOC && take) begin
            found_in = 1'b1;
            pick_in  = part_addr;
            best_in  = cur_size;
         end
         if (req_ff.opcode == OP_FINISH && proc_active
             && SUM_W'(cur_unplaced) <= sum_ff && cur_unplaced > ext_ff) begin
            ext_in = cur_unplaced;
         end
      end
      if (cmd.commit) begin
         rsp_in                = '0;
         rsp_in.kind           = req_ff.opcode;
         rsp_in.internal_total = sum_ff;
         unique case (req_ff.opcode)
            OP_ALLOC: begin
               if (fit_ok) begin
                  rsp_in.placed         = 1'b1;
                  rsp_in.placed_index   = 4'(pick_ff);
                  rsp_in.leftover       = left;
                  rsp_in.internal_total = sum_sat;
                  sum_in                = sum_sat;
               end else if (count_ff < PROC_CNT_W'(MAX_PROCS)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            OP_FINISH: begin
               rsp_in.external_frag = ext_ff;
               sum_in               = '0;
               count_in             = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIRST;
         parts_ff  <= PARTS_W'(MAX_PARTS);
         sum_ff    <= '0;
         count_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FIT_POLICY:   policy_ff <= csr_wdata[POLICY_W-1:0];
               CSR_PARTS_IN_USE: parts_ff  <= csr_wdata[PARTS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      ext_ff         <= ext_in;
      rsp_ff         <= rsp_in;
      size_rd_ff     <= part_size_mem[cnt_in[PART_IDX_W-1:0]];
      unplaced_rd_ff <= unplaced_mem[cnt_in[PROC_IDX_W-1:0]];
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (cmd.commit && req_ff.opcode == OP_LOAD) begin
         part_size_mem[req_ff.part_index[PART_IDX_W-1:0]]  <= req_ff.part_size;
         part_filled_ff[req_ff.part_index[PART_IDX_W-1:0]] <= req_ff.part_busy;
      end
      if (cmd.commit && req_ff.opcode == OP_ALLOC && fit_ok) begin
         part_filled_ff[pick_ff] <= 1'b1;
      end
      if (cmd.commit && req_ff.opcode == OP_ALLOC && !fit_ok
          && count_ff < PROC_CNT_W'(MAX_PROCS)) begin
         unplaced_mem[count_ff[PROC_IDX_W-1:0]] <= req_ff.process_size;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/fixed_partition_fit_allocator_core.sv =====
// Top level of the fixed partition fit allocator: controller, datapath and ports.
// A load item goes from accept straight to commit; an allocate or finish item goes
// from accept through a scan that visits one partition or one unplaced entry
// per cycle to commit; an item with the unused opcode is only accepted and gives no
// result. The commit also waits while the output register holds an untaken result.
// Only one item is in work at a time; the scan over the stores sets the rate. The user
// must write configuration between items for it to act on the next item; not enforced.
module fixed_partition_fit_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fpfa_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fpfa_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fpfa_pkg::*;

   cmd_type    cmd;
   status_type status;

   fpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   fpfa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
